@@ rtl/core/tnpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tnpc_pkg
// Shared types, constants and helpers of the near-plane triangle clipper.
// ----------------------------------------------------------------------------
package tnpc_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int SPLIT_BITS  = 24;
	// difference of two coordinates needs one bit more
	localparam int DW = COORD_WIDTH + 1;
	// t in [0, 1] with FRAC_BITS fraction bits
	localparam int TW = FRAC_BITS + 1;
	localparam int HI_W = DW - SPLIT_BITS;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DW-1:0]          diff_t;
	typedef logic        [DW-1:0]          mag_t;
	typedef logic        [TW-1:0]          tval_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vtx_t;

	typedef struct packed {
		coord_t px;
		coord_t py;
		coord_t pz;
		logic   last;
	} point_t;

	typedef struct packed {
		coord_t ax; coord_t ay; coord_t az;
		coord_t bx; coord_t by; coord_t bz;
		coord_t cx; coord_t cy; coord_t cz;
	} tri_t;

	// pivot vertex, the two others in cyclic order, and the front count
	typedef struct packed {
		vtx_t       me;
		vtx_t       o1;
		vtx_t       o2;
		logic [1:0] cnt;   // 0 none, 1 one front, 2 two front, 3 all
	} sel_t;

	// how a divider lane forms its quotient
	typedef enum logic [1:0] {
		DIV_ZERO,
		DIV_ONE,
		DIV_FRAC
	} div_mode_t;

	localparam coord_t NEG_ONE = coord_t'(-(64'sd1 <<< FRAC_BITS));
	localparam tval_t  T_ONE   = tval_t'(1) << FRAC_BITS;

	// magnitude of a signed difference
	function automatic mag_t mag_of(input diff_t v);
		mag_of = v[DW-1] ? mag_t'(-v) : mag_t'(v);
	endfunction

	// saturate a wide signed sum into a coordinate
	function automatic coord_t sat_c(input logic signed [DW:0] v);
		logic signed [DW:0] mx;
		logic signed [DW:0] mn;
		mx = (DW+1)'({(COORD_WIDTH-1){1'b1}});
		mn = -mx - (DW+1)'(1);
		if (v > mx) sat_c = mx[COORD_WIDTH-1:0];
		else if (v < mn) sat_c = mn[COORD_WIDTH-1:0];
		else sat_c = v[COORD_WIDTH-1:0];
	endfunction

endpackage

@@ rtl/core/tnpc_if.sv @@
// ----------------------------------------------------------------------------
// tnpc_tri_if / tnpc_pt_if
// Valid/ready channels for triangles in and points out.
// ----------------------------------------------------------------------------
interface tnpc_tri_if;
	logic valid;
	logic ready;
	tnpc_pkg::coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
	modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
	modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface tnpc_pt_if;
	logic valid;
	logic ready;
	tnpc_pkg::coord_t px, py, pz;
	logic last;
	modport source (output valid, px, py, pz, last, input ready);
	modport sink   (input valid, px, py, pz, last, output ready);
endinterface

@@ rtl/core/tnpc_div.sv @@
// ----------------------------------------------------------------------------
// tnpc_div
// Pipelined restoring divider for both crossing edges: t = n / d, FRAC_BITS
// quotient bits, one per stage, saturated to one. Carries the vertex
// selection alongside.
// ----------------------------------------------------------------------------
module tnpc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  tnpc_pkg::mag_t      n,
	input  tnpc_pkg::mag_t      d1,
	input  tnpc_pkg::mag_t      d2,
	input  logic                force1,
	input  logic                force2,
	input  tnpc_pkg::sel_t      pin,
	output logic                out_valid,
	output tnpc_pkg::tval_t     t1,
	output tnpc_pkg::tval_t     t2,
	output tnpc_pkg::sel_t      pout
);
	localparam int N = tnpc_pkg::FRAC_BITS;
	localparam int RW = tnpc_pkg::DW + 1;

	logic [N:0]                 v_s;
	logic [RW-1:0]              r1_s  [N+1];
	logic [RW-1:0]              r2_s  [N+1];
	tnpc_pkg::mag_t             d1_s  [N+1];
	tnpc_pkg::mag_t             d2_s  [N+1];
	logic [N-1:0]               q1_s  [N+1];
	logic [N-1:0]               q2_s  [N+1];
	tnpc_pkg::div_mode_t        md1_s [N+1];
	tnpc_pkg::div_mode_t        md2_s [N+1];
	tnpc_pkg::sel_t             p_s   [N+1];

	// zero on a guard case, one when the quotient reaches one
	function automatic tnpc_pkg::div_mode_t mode_of(input logic f, input tnpc_pkg::mag_t nn,
			input tnpc_pkg::mag_t dd);
		if (f || dd == '0) mode_of = tnpc_pkg::DIV_ZERO;
		else if (nn >= dd) mode_of = tnpc_pkg::DIV_ONE;
		else mode_of = tnpc_pkg::DIV_FRAC;
	endfunction

	function automatic tnpc_pkg::tval_t t_of(input tnpc_pkg::div_mode_t md,
			input logic [N-1:0] q);
		case (md)
			tnpc_pkg::DIV_ONE:  t_of = tnpc_pkg::T_ONE;
			tnpc_pkg::DIV_FRAC: t_of = {1'b0, q};
			default:            t_of = '0;
		endcase
	endfunction

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s <= '0;
		else if (en) v_s <= {v_s[N-1:0], in_valid};
	end

	// one quotient bit per stage on each edge
	always_ff @(posedge clk) begin
		if (en) begin
			r1_s[0]  <= RW'(n);
			r2_s[0]  <= RW'(n);
			d1_s[0]  <= d1;
			d2_s[0]  <= d2;
			q1_s[0]  <= '0;
			q2_s[0]  <= '0;
			md1_s[0] <= mode_of(force1, n, d1);
			md2_s[0] <= mode_of(force2, n, d2);
			p_s[0]   <= pin;
			for (int i = 0; i < N; i++) begin
				logic [RW-1:0] a1;
				logic [RW-1:0] a2;
				a1 = r1_s[i] << 1;
				a2 = r2_s[i] << 1;
				d1_s[i+1]  <= d1_s[i];
				d2_s[i+1]  <= d2_s[i];
				md1_s[i+1] <= md1_s[i];
				md2_s[i+1] <= md2_s[i];
				p_s[i+1]   <= p_s[i];
				if (a1 >= RW'(d1_s[i])) begin
					r1_s[i+1] <= a1 - RW'(d1_s[i]);
					q1_s[i+1] <= {q1_s[i][N-2:0], 1'b1};
				end else begin
					r1_s[i+1] <= a1;
					q1_s[i+1] <= {q1_s[i][N-2:0], 1'b0};
				end
				if (a2 >= RW'(d2_s[i])) begin
					r2_s[i+1] <= a2 - RW'(d2_s[i]);
					q2_s[i+1] <= {q2_s[i][N-2:0], 1'b1};
				end else begin
					r2_s[i+1] <= a2;
					q2_s[i+1] <= {q2_s[i][N-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_s[N];
	assign pout      = p_s[N];
	assign t1        = t_of(md1_s[N], q1_s[N]);
	assign t2        = t_of(md2_s[N], q2_s[N]);

endmodule

@@ rtl/core/triangle_near_plane_clipper.sv @@
// ----------------------------------------------------------------------------
// triangle_near_plane_clipper
// Clips one triangle against the plane z = -1 and emits its points.
// ----------------------------------------------------------------------------
// Usage:
//   tri (sink): one triangle a, b, c per transfer, signed Q16.16 coordinates.
//   pt (source): points px, py, pz; last marks the final point of a run.
//   A triangle wholly behind the plane gives no points, one with one vertex
//   in front gives three, two in front gives four (a quad), three gives three.
// Pipeline: a triangle passes classify, edge setup, a 17-register divider that
//   resolves one quotient bit per stage for both crossing edges, a split
//   multiply stage, a sum stage and the output register before its first
//   point is sent.
// Throughput: the pipeline advances whenever the serializer is idle or sends
//   its final point; the serializer sends one point per cycle while pt is ready,
//   so intake waits on the point list of each triangle, set by its point count.
// Reset: clears all valid bits and the serializer; no triangle is held.
// Stall: when pt is not ready the serializer holds, the whole pipeline
//   freezes and tri.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module triangle_near_plane_clipper (
	input  logic clk,
	input  logic arst_n,
	tnpc_tri_if.sink tri_in,
	tnpc_pt_if.source pt
);
	localparam int DW = tnpc_pkg::DW;
	localparam int SB = tnpc_pkg::SPLIT_BITS;
	localparam int FB = tnpc_pkg::FRAC_BITS;
	localparam int TW = tnpc_pkg::TW;
	localparam int HW = tnpc_pkg::HI_W;

	logic en;
	logic [2:0] cnt_q;
	logic [1:0] idx_q;
	logic       busy_q;
	tnpc_pkg::point_t pts_q [4];

	// stage 1: classify and pick the pivot vertex
	logic v_s1;
	tnpc_pkg::sel_t sel_s1;
	tnpc_pkg::sel_t sel_c;
	tnpc_pkg::vtx_t va, vb, vc;
	logic fa, fb, fc;

	assign va = '{tri_in.ax, tri_in.ay, tri_in.az};
	assign vb = '{tri_in.bx, tri_in.by, tri_in.bz};
	assign vc = '{tri_in.cx, tri_in.cy, tri_in.cz};
	assign fa = tri_in.az <= tnpc_pkg::NEG_ONE;
	assign fb = tri_in.bz <= tnpc_pkg::NEG_ONE;
	assign fc = tri_in.cz <= tnpc_pkg::NEG_ONE;

	always_comb begin
		logic [1:0] c;
		c = 2'(fa) + 2'(fb) + 2'(fc);
		sel_c = '{va, vb, vc, c};
		if (c == 2'd1) begin
			if (fb) sel_c = '{vb, vc, va, c};
			else if (fc) sel_c = '{vc, va, vb, c};
		end else if (c == 2'd2) begin
			if (!fb) sel_c = '{vb, vc, va, c};
			else if (!fc) sel_c = '{vc, va, vb, c};
		end else if (c == 2'd0 && fa == 1'b0 && fb == 1'b0 && fc == 1'b0) begin
			sel_c = '{va, vb, vc, 2'd0};
		end
	end

	assign en = !busy_q || (pt.ready && idx_q == cnt_q[1:0] - 2'd1 && cnt_q != 3'd0);
	assign tri_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= tri_in.valid;
	end
	always_ff @(posedge clk) if (en) sel_s1 <= sel_c;

	// stage 2: numerator and divisors for both edges
	logic v_s2;
	tnpc_pkg::sel_t sel_s2;
	tnpc_pkg::mag_t n_s2, d1_s2, d2_s2;
	logic z1_s2, z2_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tnpc_pkg::diff_t num, dz1, dz2;
			num = -(DW'(sel_s1.me.z) + (DW'(1) << FB));
			dz1 = DW'(sel_s1.o1.z) - DW'(sel_s1.me.z);
			dz2 = DW'(sel_s1.o2.z) - DW'(sel_s1.me.z);
			sel_s2 <= sel_s1;
			n_s2   <= tnpc_pkg::mag_of(num);
			d1_s2  <= tnpc_pkg::mag_of(dz1);
			d2_s2  <= tnpc_pkg::mag_of(dz2);
			z1_s2  <= (num[DW-1] && !dz1[DW-1] && dz1 != '0) ||
				(!num[DW-1] && num != '0 && dz1[DW-1]);
			z2_s2  <= (num[DW-1] && !dz2[DW-1] && dz2 != '0) ||
				(!num[DW-1] && num != '0 && dz2[DW-1]);
		end
	end

	// divider pipeline for both edges
	logic v_d;
	tnpc_pkg::tval_t t1_d, t2_d;
	tnpc_pkg::sel_t sel_d;

	tnpc_div u_div (
		.clk, .arst_n, .en, .in_valid(v_s2), .n(n_s2), .d1(d1_s2), .d2(d2_s2),
		.force1(z1_s2), .force2(z2_s2), .pin(sel_s2), .out_valid(v_d),
		.t1(t1_d), .t2(t2_d), .pout(sel_d)
	);

	// stage 3: partial products of |d| * t, split at SPLIT_BITS
	logic v_s3;
	tnpc_pkg::sel_t sel_s3;
	logic [HW+TW-1:0] hi_s3 [6];
	logic [SB+TW-1:0] lo_s3 [6];
	logic             ng_s3 [6];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_d;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tnpc_pkg::diff_t dv;
			tnpc_pkg::mag_t  m;
			tnpc_pkg::tval_t tt;
			sel_s3 <= sel_d;
			for (int k = 0; k < 6; k++) begin
				case (k)
					0: dv = DW'(sel_d.o1.x) - DW'(sel_d.me.x);
					1: dv = DW'(sel_d.o1.y) - DW'(sel_d.me.y);
					2: dv = DW'(sel_d.o1.z) - DW'(sel_d.me.z);
					3: dv = DW'(sel_d.o2.x) - DW'(sel_d.me.x);
					4: dv = DW'(sel_d.o2.y) - DW'(sel_d.me.y);
					default: dv = DW'(sel_d.o2.z) - DW'(sel_d.me.z);
				endcase
				tt = (k < 3) ? t1_d : t2_d;
				m = tnpc_pkg::mag_of(dv);
				ng_s3[k] <= dv[DW-1];
				hi_s3[k] <= (HW+TW)'(m[DW-1:SB]) * (HW+TW)'(tt);
				lo_s3[k] <= (SB+TW)'(m[SB-1:0]) * (SB+TW)'(tt);
			end
		end
	end

	// stage 4: combine, add to pivot, saturate, build the point list
	logic v_s4;
	tnpc_pkg::point_t pl_s4 [4];
	logic [2:0] n_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3 && (sel_s3.cnt != 2'd0);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			logic [DW+TW:0] pr;
			logic signed [DW:0] sm;
			tnpc_pkg::coord_t q [6];
			tnpc_pkg::coord_t mc;
			for (int k = 0; k < 6; k++) begin
				pr = ((DW+TW+1)'(hi_s3[k]) << (SB-FB)) + (DW+TW+1)'(lo_s3[k] >> FB);
				mc = (k % 3 == 0) ? sel_s3.me.x : (k % 3 == 1) ? sel_s3.me.y : sel_s3.me.z;
				sm = ng_s3[k] ? (DW+1)'(mc) - (DW+1)'(pr) : (DW+1)'(mc) + (DW+1)'(pr);
				q[k] = tnpc_pkg::sat_c(sm);
			end
			case (sel_s3.cnt)
				2'd1: begin
					pl_s4[0] <= '{sel_s3.me.x, sel_s3.me.y, sel_s3.me.z, 1'b0};
					pl_s4[1] <= '{q[0], q[1], q[2], 1'b0};
					pl_s4[2] <= '{q[3], q[4], q[5], 1'b1};
					pl_s4[3] <= '{q[3], q[4], q[5], 1'b1};
					n_s4 <= 3'd3;
				end
				2'd2: begin
					pl_s4[0] <= '{q[0], q[1], q[2], 1'b0};
					pl_s4[1] <= '{q[3], q[4], q[5], 1'b0};
					pl_s4[2] <= '{sel_s3.o1.x, sel_s3.o1.y, sel_s3.o1.z, 1'b0};
					pl_s4[3] <= '{sel_s3.o2.x, sel_s3.o2.y, sel_s3.o2.z, 1'b1};
					n_s4 <= 3'd4;
				end
				default: begin
					pl_s4[0] <= '{sel_s3.me.x, sel_s3.me.y, sel_s3.me.z, 1'b0};
					pl_s4[1] <= '{sel_s3.o1.x, sel_s3.o1.y, sel_s3.o1.z, 1'b0};
					pl_s4[2] <= '{sel_s3.o2.x, sel_s3.o2.y, sel_s3.o2.z, 1'b1};
					pl_s4[3] <= '{sel_s3.o2.x, sel_s3.o2.y, sel_s3.o2.z, 1'b1};
					n_s4 <= 3'd3;
				end
			endcase
		end
	end

	// output serializer: loads a point list, sends one point per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			cnt_q  <= '0;
		end else if (en) begin
			busy_q <= v_s4;
			idx_q  <= '0;
			cnt_q  <= n_s4;
		end else if (pt.ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end
	always_ff @(posedge clk) if (en) pts_q <= pl_s4;

	assign pt.valid = busy_q;
	assign pt.px    = pts_q[idx_q].px;
	assign pt.py    = pts_q[idx_q].py;
	assign pt.pz    = pts_q[idx_q].pz;
	assign pt.last  = pts_q[idx_q].last;

endmodule

@@ rtl/core/tnpc_checker.sv @@
// ----------------------------------------------------------------------------
// tnpc_checker
// Port-level checks of the clipper, bound to the top level.
// ----------------------------------------------------------------------------
module tnpc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_last,
	input tnpc_pkg::coord_t px
);
	// a stalled point stays valid and keeps its px
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(px)) else $error("point dropped");
	// no intake while a point is stalled
	a_noin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready) else $error("intake during stall");
	// after a non-final point is sent another follows
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid) else $error("run broken");
endmodule

bind triangle_near_plane_clipper tnpc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(tri_in.ready), .out_valid(pt.valid),
	.out_ready(pt.ready), .out_last(pt.last), .px(pt.px)
);

@@ dv/tnpc_tb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnpc_tb_if
// Testbench side of the clipper channels: reuses the block's interfaces.
// ----------------------------------------------------------------------------
// the channel interfaces come with the RTL; this file holds a small record
// of a triangle transfer
package tnpc_tb_pkg;
	typedef struct {
		tnpc_pkg::coord_t v[3][3];
	} tri_rec_t;
endpackage

@@ dv/triangle_near_plane_clipper_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_near_plane_clipper_tb
// Drives triangles through the near-plane clipper and checks every point.
// A fixed-point predictor computes the expected points of each accepted
// triangle; a scoreboard compares each point transfer against them in order.
// ----------------------------------------------------------------------------
class clip_scoreboard;
	tnpc_pkg::point_t pending[$];
	int errors;

	function longint sx(tnpc_pkg::coord_t v);
		sx = longint'(v);
	endfunction

	// restoring division, saturated to one
	function longint quot(longint n, longint d);
		longint q, r;
		q = 0;
		r = n;
		if (d == 0) return 0;
		if (n >= d) return longint'(1) << tnpc_pkg::FRAC_BITS;
		for (int i = 0; i < tnpc_pkg::FRAC_BITS; i++) begin
			r = r <<< 1;
			q = q <<< 1;
			if (r >= d) begin
				r -= d;
				q |= 1;
			end
		end
		return q;
	endfunction

	function longint scale(longint v, longint t);
		longint m, p;
		m = v < 0 ? -v : v;
		p = ((m >>> tnpc_pkg::SPLIT_BITS) * t <<< (tnpc_pkg::SPLIT_BITS - tnpc_pkg::FRAC_BITS))
			+ (((m & ((longint'(1) << tnpc_pkg::SPLIT_BITS) - 1)) * t)
			>>> tnpc_pkg::FRAC_BITS);
		return v < 0 ? -p : p;
	endfunction

	function longint clamp(longint v);
		longint mx;
		mx = (longint'(1) << (tnpc_pkg::COORD_WIDTH - 1)) - 1;
		if (v > mx) return mx;
		if (v < -mx - 1) return -mx - 1;
		return v;
	endfunction

	function tnpc_pkg::point_t crossing(tnpc_tb_pkg::tri_rec_t t, int me, int other,
			logic lst);
		longint dz, num, tv, r[3];
		tnpc_pkg::point_t p;
		dz = sx(t.v[other][2]) - sx(t.v[me][2]);
		num = -((longint'(1) << tnpc_pkg::FRAC_BITS) + sx(t.v[me][2]));
		tv = 0;
		if (dz != 0 && !((num < 0 && dz > 0) || (num > 0 && dz < 0)))
			tv = quot(num < 0 ? -num : num, dz < 0 ? -dz : dz);
		for (int i = 0; i < 3; i++)
			r[i] = clamp(sx(t.v[me][i]) + scale(sx(t.v[other][i]) - sx(t.v[me][i]), tv));
		p.px = tnpc_pkg::coord_t'(r[0]);
		p.py = tnpc_pkg::coord_t'(r[1]);
		p.pz = tnpc_pkg::coord_t'(r[2]);
		p.last = lst;
		return p;
	endfunction

	function tnpc_pkg::point_t vertex(tnpc_tb_pkg::tri_rec_t t, int i, logic lst);
		tnpc_pkg::point_t p;
		p.px = t.v[i][0];
		p.py = t.v[i][1];
		p.pz = t.v[i][2];
		p.last = lst;
		return p;
	endfunction

	// expected points of one accepted triangle
	function void note_triangle(tnpc_tb_pkg::tri_rec_t t);
		int cnt, fi, bi;
		cnt = 0;
		fi = 0;
		bi = 0;
		for (int i = 0; i < 3; i++)
			if (t.v[i][2] <= tnpc_pkg::NEG_ONE) begin
				cnt++;
				fi = i;
			end else
				bi = i;
		case (cnt)
			1: begin
				pending.push_back(vertex(t, fi, 0));
				pending.push_back(crossing(t, fi, (fi + 1) % 3, 0));
				pending.push_back(crossing(t, fi, (fi + 2) % 3, 1));
			end
			2: begin
				pending.push_back(crossing(t, bi, (bi + 1) % 3, 0));
				pending.push_back(crossing(t, bi, (bi + 2) % 3, 0));
				pending.push_back(vertex(t, (bi + 1) % 3, 0));
				pending.push_back(vertex(t, (bi + 2) % 3, 1));
			end
			3: begin
				for (int i = 0; i < 3; i++)
					pending.push_back(vertex(t, i, i == 2));
			end
			default: ;
		endcase
	endfunction

	function void check_point(tnpc_pkg::point_t got);
		tnpc_pkg::point_t want;
		if (pending.size() == 0) begin
			$error("point with no expected point: %h", got);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.px !== want.px) begin
			$error("px expected %h got %h", want.px, got.px);
			errors++;
		end
		if (got.py !== want.py) begin
			$error("py expected %h got %h", want.py, got.py);
			errors++;
		end
		if (got.pz !== want.pz) begin
			$error("pz expected %h got %h", want.pz, got.pz);
			errors++;
		end
		if (got.last !== want.last) begin
			$error("last expected %b got %b", want.last, got.last);
			errors++;
		end
	endfunction
endclass

module triangle_near_plane_clipper_tb;
	logic clk;
	logic arst_n;
	tnpc_tri_if tri_ch();
	tnpc_pt_if pt_ch();
	clip_scoreboard sb;
	int unsigned cycles;
	bit hold_long;

	triangle_near_plane_clipper dut (
		.clk(clk),
		.arst_n(arst_n),
		.tri_in(tri_ch.sink),
		.pt(pt_ch.source)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		tri_ch.valid = 1'b0;
		{tri_ch.ax, tri_ch.ay, tri_ch.az, tri_ch.bx, tri_ch.by, tri_ch.bz,
			tri_ch.cx, tri_ch.cy, tri_ch.cz} = '0;
		pt_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// check every point transfer at the clock edge
	always @(posedge clk) begin
		if (arst_n && pt_ch.valid && pt_ch.ready)
			sb.check_point('{pt_ch.px, pt_ch.py, pt_ch.pz, pt_ch.last});
	end

	// point receiver with random stalls and one long hold-off
	initial begin
		int w;
		int n;
		n = 0;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				pt_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_long = 0;
			end
			w = (n % 97 < 20) ? 0 : $urandom_range(0, 17);
			n++;
			if (w > 0) begin
				pt_ch.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			pt_ch.ready <= 1'b1;
			do @(posedge clk); while (!pt_ch.valid);
		end
	end

	function automatic tnpc_pkg::coord_t rnd_z();
		case ($urandom_range(0, 5))
			0: return tnpc_pkg::NEG_ONE;
			1: return tnpc_pkg::NEG_ONE + 1;
			2: return tnpc_pkg::coord_t'($urandom);
			3: return tnpc_pkg::coord_t'(-$signed($urandom_range(0, 32'h000a0000)));
			4: return tnpc_pkg::coord_t'($signed($urandom_range(0, 32'h00050000))
				- 32'sh00030000);
			default: return tnpc_pkg::coord_t'($urandom_range(0, 32'h7fffffff)) | 32'h80000000;
		endcase
	endfunction

	// one triangle transfer
	task automatic send_tri(tnpc_tb_pkg::tri_rec_t t, int gap);
		if (gap > 0) begin
			tri_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tri_ch.valid <= 1'b1;
		{tri_ch.ax, tri_ch.ay, tri_ch.az} <= {t.v[0][0], t.v[0][1], t.v[0][2]};
		{tri_ch.bx, tri_ch.by, tri_ch.bz} <= {t.v[1][0], t.v[1][1], t.v[1][2]};
		{tri_ch.cx, tri_ch.cy, tri_ch.cz} <= {t.v[2][0], t.v[2][1], t.v[2][2]};
		do @(posedge clk); while (!tri_ch.ready);
		sb.note_triangle(t);
	endtask

	// directed corners, then random triangles
	initial begin
		tnpc_tb_pkg::tri_rec_t t;
		tnpc_pkg::coord_t ext[4];
		int idle;
		ext = '{32'sh7fffffff, 32'sh80000000, 0, tnpc_pkg::NEG_ONE};
		@(posedge arst_n);
		@(posedge clk);
		for (int k = 0; k < 24; k++) begin
			for (int i = 0; i < 3; i++) begin
				t.v[i][0] = ext[(k + i) % 4];
				t.v[i][1] = ext[(k + 2 * i + 1) % 4];
				t.v[i][2] = ((k >> i) & 1) ? ext[(k / 8 + i) % 2 * 2 + 1] :
					ext[(k / 8 + i) % 3 == 1 ? 0 : 2];
			end
			send_tri(t, k % 3);
		end
		for (int k = 0; k < 340; k++) begin
			if (k == 100) hold_long = 1;
			for (int i = 0; i < 3; i++) begin
				t.v[i][0] = ($urandom_range(0, 3) == 0) ? tnpc_pkg::coord_t'($urandom) :
					tnpc_pkg::coord_t'($signed($urandom_range(0, 32'h00200000))
					- 32'sh00100000);
				t.v[i][1] = tnpc_pkg::coord_t'($urandom);
				t.v[i][2] = rnd_z();
			end
			idle = (k % 60 < 15 || (k >= 100 && k < 140)) ? 0 : $urandom_range(0, 17);
			send_tri(t, idle);
		end
		tri_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
